FILE: rtl/core/lslf_pkg.sv
// Shared constants, types and codes of the least-squares line fit block.
package lslf_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    localparam int PT_W    = 10;
    localparam int OUT_W   = 32;
    localparam int VX_W    = 26;
    localparam int QW      = OUT_W + 1;

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int SX_W    = COORD_BITS + IDX_W;
    localparam int SXX_W   = 2 * COORD_BITS + IDX_W;
    localparam int PROD_W  = SXX_W + SX_W;
    localparam int NUM_W   = PROD_W + FRAC_BITS + 2;
    localparam int MSTEP_W = $clog2(SX_W + 1);
    localparam int DSTEP_W = $clog2(NUM_W + 1);

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SX_W-1:0]  sx;
        logic [SX_W-1:0]  sy;
        logic [SXX_W-1:0] sxy;
        logic [SXX_W-1:0] sxx;
        logic             ovf;
    } t_sums;

    typedef enum logic [3:0] {
        ST_ACC = 4'b0001,
        ST_MUL = 4'b0010,
        ST_DIV = 4'b0100,
        ST_FIN = 4'b1000
    } t_state;

    // Products formed one after another by the serial multiplier.
    typedef enum logic [2:0] {
        P_N_XX  = 3'd0,
        P_SX_SX = 3'd1,
        P_N_XY  = 3'd2,
        P_SX_SY = 3'd3,
        P_XX_SY = 3'd4,
        P_SX_XY = 3'd5
    } t_prod;

endpackage

FILE: rtl/core/lslf_if.sv
// Point and result channel interfaces of the least-squares line fit block.
interface lslf_pt_if import lslf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
    logic            last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface lslf_res_if import lslf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] slope;
    logic signed [OUT_W-1:0] intercept;
    logic [VX_W-1:0]         vertical_x;
    logic                    vert_flag;
    logic                    saturated;
    logic                    too_many_points;

    modport source (output valid, output slope, output intercept, output vertical_x,
                    output vert_flag, output saturated, output too_many_points,
                    input ready);
    modport sink   (input valid, input slope, input intercept, input vertical_x,
                    input vert_flag, input saturated, input too_many_points,
                    output ready);
endinterface

FILE: rtl/core/lslf_accum.sv
// Point accumulator: exact count and sums of x, y, x*y and x*x.
module lslf_accum import lslf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  logic                  i_clear,
    output t_sums                 o_sums
);

    t_sums                     r_sums;
    logic [2*COORD_BITS-1:0]   w_xy;
    logic [2*COORD_BITS-1:0]   w_xx;

    assign w_xy = (2*COORD_BITS)'(i_x) * (2*COORD_BITS)'(i_y);
    assign w_xx = (2*COORD_BITS)'(i_x) * (2*COORD_BITS)'(i_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sums <= '0;
        end else if (i_take) begin
            if (r_sums.cnt < CNT_W'(MAX_POINTS)) begin
                r_sums.cnt <= r_sums.cnt + CNT_W'(1);
                r_sums.sx  <= r_sums.sx + SX_W'(i_x);
                r_sums.sy  <= r_sums.sy + SX_W'(i_y);
                r_sums.sxy <= r_sums.sxy + SXX_W'(w_xy);
                r_sums.sxx <= r_sums.sxx + SXX_W'(w_xx);
            end else begin
                // The set is full: the point is dropped and the result flags it.
                r_sums.ovf <= 1'b1;
            end
        end
    end

    assign o_sums = r_sums;

endmodule

FILE: rtl/core/lslf_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module lslf_smul import lslf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SXX_W-1:0]  i_a,
    input  logic [SX_W-1:0]   i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    logic [SXX_W-1:0]   r_a;
    logic [SX_W-1:0]    r_b;
    logic [PROD_W-1:0]  r_acc;
    logic [MSTEP_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [SXX_W:0]     w_sum;

    assign w_sum = {1'b0, r_acc[PROD_W-1:SX_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MSTEP_W'(SX_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - MSTEP_W'(1);
                if (r_cnt == MSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The partial product shifts right as each multiplier bit is retired.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= {w_sum, r_acc[SX_W-1:1]};
            r_b   <= {1'b0, r_b[SX_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/core/lslf_sdiv.sv
// Restoring divider, one quotient bit per cycle, rounding to nearest.
module lslf_sdiv import lslf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_mag,
    input  logic [PROD_W-1:0] i_den,
    output logic              o_done,
    output logic [QW-1:0]     o_quo,
    output logic              o_big
);

    logic [NUM_W-1:0]   r_num;
    logic [PROD_W:0]    r_rem;
    logic [PROD_W:0]    r_dv;
    logic [QW-1:0]      r_q;
    logic               r_big;
    logic [DSTEP_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [PROD_W+1:0]  w_trial;
    logic [PROD_W+1:0]  w_diff;
    logic               w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dv};
    assign w_diff  = w_trial - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DSTEP_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DSTEP_W'(1);
                if (r_cnt == DSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Dividing mag*2^(F+1) + den by 2*den gives the quotient rounded half up.
    // Only the low quotient bits are kept; any higher set bit marks overflow.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {1'b0, i_mag, {(FRAC_BITS + 1){1'b0}}}
                     + {{(NUM_W - PROD_W){1'b0}}, i_den};
            r_dv  <= {i_den, 1'b0};
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[PROD_W:0] : w_trial[PROD_W:0];
            r_q   <= {r_q[QW-2:0], w_ge};
            r_big <= r_big | r_q[QW-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_big  = r_big;

endmodule

FILE: rtl/core/least_squares_line_fit_top.sv
// Least-squares line fit over a set of points: top level with sequencer and output register.
// Points are taken one per cycle while the block accumulates; the point marked last closes
// the set, and the point channel then stays not ready until the fit is done and handed to
// the result register. A fit forms six 30x20-bit products through a serial multiplier at
// one bit per cycle and two 68-bit restoring divisions at one quotient bit per cycle; a
// fit with a vertical line needs two products and one division. The result register is
// then loaded; loading waits while it still holds a result that has not been taken.
// A finished result waits in the output register while the next set accumulates; slope and
// intercept are signed Q15.16 rounded to nearest, with an exact half rounded away from zero.
module least_squares_line_fit_top import lslf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lslf_pt_if.sink    i_pt,
    lslf_res_if.source o_res
);

    localparam logic [QW-1:0] POS_LIM = {2'b00, {(OUT_W - 1){1'b1}}};
    localparam logic [QW-1:0] NEG_LIM = {2'b01, {(OUT_W - 1){1'b0}}};
    localparam logic [QW-1:0] VX_LIM  = {{(QW - VX_W){1'b0}}, {VX_W{1'b1}}};

    t_state                  r_state;
    t_prod                   r_step;
    logic                    r_mul_go;
    logic                    r_div_go;
    logic                    r_vert;
    logic                    r_neg;
    logic                    r_sat;
    logic [PROD_W-1:0]       r_pa;
    logic [PROD_W-1:0]       r_d;
    logic [PROD_W-1:0]       r_dmag;
    logic [PROD_W-1:0]       r_dden;
    logic signed [OUT_W-1:0] r_slope;
    logic signed [OUT_W-1:0] r_icpt;
    logic [VX_W-1:0]         r_vx;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_slope;
    logic signed [OUT_W-1:0] r_out_icpt;
    logic [VX_W-1:0]         r_out_vx;
    logic                    r_out_vert;
    logic                    r_out_sat;
    logic                    r_out_many;

    t_sums                   w_sums;
    logic                    w_take;
    logic                    w_load;
    logic [SXX_W-1:0]        w_ma;
    logic [SX_W-1:0]         w_mb;
    logic                    w_mul_done;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_div_done;
    logic [QW-1:0]           w_quo;
    logic                    w_big;
    logic                    w_ge;
    logic [PROD_W-1:0]       w_dpos;
    logic [PROD_W-1:0]       w_dneg;
    logic                    w_pos_sat;
    logic                    w_neg_sat;
    logic                    w_vx_sat;
    logic [QW-1:0]           w_neg_mag;
    logic signed [OUT_W-1:0] w_fix;
    logic                    w_fix_sat;

    assign w_take      = i_pt.valid && i_pt.ready;
    assign i_pt.ready  = (r_state == ST_ACC);
    assign w_load      = (r_state == ST_FIN) && (!r_out_valid || o_res.ready);

    lslf_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_x     (i_pt.point_x[COORD_BITS-1:0]),
        .i_y     (i_pt.point_y[COORD_BITS-1:0]),
        .i_clear (w_load),
        .o_sums  (w_sums)
    );

    always_comb begin
        case (r_step)
            P_N_XX: begin
                w_ma = w_sums.sxx;
                w_mb = {{(SX_W - CNT_W){1'b0}}, w_sums.cnt};
            end
            P_SX_SX: begin
                w_ma = {{(SXX_W - SX_W){1'b0}}, w_sums.sx};
                w_mb = w_sums.sx;
            end
            P_N_XY: begin
                w_ma = w_sums.sxy;
                w_mb = {{(SX_W - CNT_W){1'b0}}, w_sums.cnt};
            end
            P_SX_SY: begin
                w_ma = {{(SXX_W - SX_W){1'b0}}, w_sums.sx};
                w_mb = w_sums.sy;
            end
            P_XX_SY: begin
                w_ma = w_sums.sxx;
                w_mb = w_sums.sy;
            end
            P_SX_XY: begin
                w_ma = w_sums.sxy;
                w_mb = w_sums.sx;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    lslf_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    lslf_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_mag   (r_dmag),
        .i_den   (r_dden),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_big   (w_big)
    );

    assign w_ge   = r_pa >= w_prod;
    assign w_dpos = r_pa - w_prod;
    assign w_dneg = w_prod - r_pa;

    assign w_pos_sat = w_big || (w_quo > POS_LIM);
    assign w_neg_sat = w_big || (w_quo > NEG_LIM);
    assign w_vx_sat  = w_big || (w_quo > VX_LIM);
    assign w_neg_mag = w_neg_sat ? NEG_LIM : w_quo;

    always_comb begin
        if (r_neg) begin
            w_fix     = -$signed(w_neg_mag[OUT_W-1:0]);
            w_fix_sat = w_neg_sat;
        end else begin
            w_fix     = w_pos_sat ? $signed(POS_LIM[OUT_W-1:0]) : $signed(w_quo[OUT_W-1:0]);
            w_fix_sat = w_pos_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACC;
            r_step      <= P_N_XX;
            r_mul_go    <= 1'b0;
            r_div_go    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_div_go <= 1'b0;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_ACC: begin
                    if (w_take && i_pt.last_point) begin
                        r_state  <= ST_MUL;
                        r_step   <= P_N_XX;
                        r_mul_go <= 1'b1;
                        r_vert   <= 1'b0;
                        r_sat    <= 1'b0;
                        r_slope  <= '0;
                        r_icpt   <= '0;
                        r_vx     <= '0;
                    end
                end
                ST_MUL: begin
                    if (w_mul_done) begin
                        case (r_step)
                            P_N_XX: begin
                                r_pa     <= w_prod;
                                r_step   <= P_SX_SX;
                                r_mul_go <= 1'b1;
                            end
                            P_SX_SX: begin
                                // n*sum_xx never falls below sum_x^2; zero means all x equal.
                                if (w_dpos == '0) begin
                                    r_vert   <= 1'b1;
                                    r_neg    <= 1'b0;
                                    r_dmag   <= {{(PROD_W - SX_W){1'b0}}, w_sums.sx};
                                    r_dden   <= {{(PROD_W - CNT_W){1'b0}}, w_sums.cnt};
                                    r_div_go <= 1'b1;
                                    r_state  <= ST_DIV;
                                end else begin
                                    r_d      <= w_dpos;
                                    r_step   <= P_N_XY;
                                    r_mul_go <= 1'b1;
                                end
                            end
                            P_N_XY: begin
                                r_pa     <= w_prod;
                                r_step   <= P_SX_SY;
                                r_mul_go <= 1'b1;
                            end
                            P_XX_SY: begin
                                r_pa     <= w_prod;
                                r_step   <= P_SX_XY;
                                r_mul_go <= 1'b1;
                            end
                            P_SX_SY, P_SX_XY: begin
                                r_dmag   <= w_ge ? w_dpos : w_dneg;
                                r_neg    <= !w_ge;
                                r_dden   <= r_d;
                                r_div_go <= 1'b1;
                                r_state  <= ST_DIV;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (r_vert) begin
                            r_vx    <= w_vx_sat ? VX_LIM[VX_W-1:0] : w_quo[VX_W-1:0];
                            r_sat   <= r_sat | w_vx_sat;
                            r_state <= ST_FIN;
                        end else if (r_step == P_SX_SY) begin
                            r_slope  <= w_fix;
                            r_sat    <= r_sat | w_fix_sat;
                            r_step   <= P_XX_SY;
                            r_mul_go <= 1'b1;
                            r_state  <= ST_MUL;
                        end else begin
                            r_icpt  <= w_fix;
                            r_sat   <= r_sat | w_fix_sat;
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (w_load) begin
                        r_out_slope <= r_slope;
                        r_out_icpt  <= r_icpt;
                        r_out_vx    <= r_vx;
                        r_out_vert  <= r_vert;
                        r_out_sat   <= r_sat;
                        r_out_many  <= w_sums.ovf;
                        r_state     <= ST_ACC;
                    end
                end
                default: begin
                    r_state <= ST_ACC;
                end
            endcase
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.slope           = r_out_slope;
    assign o_res.intercept       = r_out_icpt;
    assign o_res.vertical_x      = r_out_vx;
    assign o_res.vert_flag       = r_out_vert;
    assign o_res.saturated       = r_out_sat;
    assign o_res.too_many_points = r_out_many;

endmodule

FILE: rtl/core/lslf_chk.sv
// Port-level checker of the line fit result channel, bound to the top level.
module lslf_chk import lslf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [OUT_W-1:0] i_slope,
    input logic signed [OUT_W-1:0] i_intercept,
    input logic [VX_W-1:0]         i_vertical_x,
    input logic                    i_vert_flag,
    input logic                    i_saturated,
    input logic                    i_too_many_points
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_slope) && $stable(i_intercept)
            && $stable(i_vertical_x) && $stable(i_vert_flag)
            && $stable(i_saturated) && $stable(i_too_many_points))
        else $error("result changed while stalled");

    a_vert_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_vert_flag |-> i_slope == 0 && i_intercept == 0)
        else $error("vertical result carries a slope or intercept");

    a_line_no_vx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_vert_flag |-> i_vertical_x == 0)
        else $error("non-vertical result carries a vertical x");

endmodule

bind least_squares_line_fit_top lslf_chk u_lslf_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_slope           (o_res.slope),
    .i_intercept       (o_res.intercept),
    .i_vertical_x      (o_res.vertical_x),
    .i_vert_flag       (o_res.vert_flag),
    .i_saturated       (o_res.saturated),
    .i_too_many_points (o_res.too_many_points)
);

FILE: sim/tb.sv
// Self-checking testbench of least_squares_line_fit_top: point sets in, fitted lines checked.
module tb;
    import lslf_pkg::*;

    localparam int          PT_MAX        = (1 << PT_W) - 1;
    localparam int          RANDOM_POINTS = 92;
    localparam int          DRAIN_CYCLES  = 400;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        logic signed [OUT_W-1:0] slope;
        logic signed [OUT_W-1:0] intercept;
        logic [VX_W-1:0]         vertical_x;
        logic                    vert_flag;
        logic                    saturated;
        logic                    too_many_points;
    } t_line_fit;

    // Exact integer sums per set; each closed set queues the line it should produce.
    class line_fit_tracker;
        typedef bit [127:0] t_wide;

        int unsigned     point_count;
        longint unsigned x_sum, y_sum, xy_sum, xx_sum;
        bit              dropped_points;
        t_line_fit       pending_fits[$];
        int unsigned     mismatches;

        // round(mag * 2^FRAC_BITS / den), exact half away from zero, clamped to limit
        function longint unsigned round_frac(t_wide mag, t_wide den, longint unsigned limit,
                                             inout bit clamped);
            t_wide q;
            q = ((mag << (FRAC_BITS + 1)) + den) / (den << 1);
            if (q > limit) begin
                clamped = 1'b1;
                return limit;
            end
            return q[63:0];
        endfunction

        // (a - b) / den as a two's complement Q.FRAC_BITS word
        function logic [OUT_W-1:0] signed_frac(t_wide a, t_wide b, t_wide den,
                                               inout bit clamped);
            longint unsigned q;
            if (a >= b) begin
                q = round_frac(a - b, den, 64'h7FFF_FFFF, clamped);
            end else begin
                q = -round_frac(b - a, den, 64'h8000_0000, clamped);
            end
            return q[OUT_W-1:0];
        endfunction

        function void add_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic last);
            t_line_fit       fit;
            t_wide           n, sx, sy, sxy, sxx, d;
            longint unsigned xv, yv, vx;
            bit              clamped;
            xv = x[COORD_BITS-1:0];
            yv = y[COORD_BITS-1:0];
            if (point_count < MAX_POINTS) begin
                point_count++;
                x_sum  += xv;
                y_sum  += yv;
                xy_sum += xv * yv;
                xx_sum += xv * xv;
            end else begin
                dropped_points = 1'b1;
            end
            if (!last) return;

            n   = point_count;
            sx  = x_sum;
            sy  = y_sum;
            sxy = xy_sum;
            sxx = xx_sum;
            d   = n * sxx - sx * sx;
            clamped = 1'b0;
            fit = '{default: '0};
            fit.vert_flag = (d == 0);
            if (d == 0) begin
                vx = round_frac(sx, n, (64'd1 << VX_W) - 1, clamped);
                fit.vertical_x = vx[VX_W-1:0];
            end else begin
                fit.slope     = signed_frac(n * sxy, sx * sy, d, clamped);
                fit.intercept = signed_frac(sxx * sy, sx * sxy, d, clamped);
            end
            fit.saturated       = clamped;
            fit.too_many_points = dropped_points;
            pending_fits.push_back(fit);

            point_count    = 0;
            x_sum          = 0;
            y_sum          = 0;
            xy_sum         = 0;
            xx_sum         = 0;
            dropped_points = 1'b0;
        endfunction

        function void check_fit(t_line_fit got);
            t_line_fit want;
            if (pending_fits.size() == 0) begin
                $error("fit result transfer with no fit outstanding");
                mismatches++;
                return;
            end
            want = pending_fits.pop_front();
            if (got.slope !== want.slope) begin
                $error("slope: expected %0d, actual %0d", want.slope, got.slope);
                mismatches++;
            end
            if (got.intercept !== want.intercept) begin
                $error("intercept: expected %0d, actual %0d", want.intercept, got.intercept);
                mismatches++;
            end
            if (got.vertical_x !== want.vertical_x) begin
                $error("vertical_x: expected %0d, actual %0d", want.vertical_x, got.vertical_x);
                mismatches++;
            end
            if (got.vert_flag !== want.vert_flag) begin
                $error("vert_flag: expected %0d, actual %0d", want.vert_flag,
                       got.vert_flag);
                mismatches++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0d, actual %0d", want.saturated, got.saturated);
                mismatches++;
            end
            if (got.too_many_points !== want.too_many_points) begin
                $error("too_many_points: expected %0d, actual %0d", want.too_many_points,
                       got.too_many_points);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   no_idle;
    int unsigned cycles;

    lslf_pt_if  pt ();
    lslf_res_if res ();

    line_fit_tracker fits = new;

    least_squares_line_fit_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt),
        .o_res   (res)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("least_squares_line_fit_top test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : take_fits
        t_line_fit got;
        if (i_rst_n && res.valid && res.ready) begin
            got.slope           = res.slope;
            got.intercept       = res.intercept;
            got.vertical_x      = res.vertical_x;
            got.vert_flag       = res.vert_flag;
            got.saturated       = res.saturated;
            got.too_many_points = res.too_many_points;
            fits.check_fit(got);
        end
        res.ready <= no_idle || ($urandom_range(99) >= 23);
    end

    // Valid stays high from one transfer into the next unless an idle cycle is drawn.
    task automatic send_point(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
                              input logic last);
        while (!no_idle && $urandom_range(99) < 23) begin
            pt.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt.valid      <= 1'b1;
        pt.point_x    <= x;
        pt.point_y    <= y;
        pt.last_point <= last;
        do @(posedge i_clk); while (!pt.ready);
        fits.add_point(x, y, last);
    endtask

    initial begin : stimulus
        int unsigned     shape, set_size, base_x, sent;
        logic [PT_W-1:0] x, y;
        pt.valid      <= 1'b0;
        pt.point_x    <= '0;
        pt.point_y    <= '0;
        pt.last_point <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single points and equal x give vertical lines.
        send_point(0, 0, 1'b1);
        send_point(PT_MAX, PT_MAX, 1'b1);
        send_point(517, 3, 1'b0);
        send_point(517, 900, 1'b0);
        send_point(517, 41, 1'b1);
        // Diagonals across the whole field and the steepest slope.
        send_point(0, 0, 1'b0);
        send_point(PT_MAX, PT_MAX, 1'b1);
        send_point(0, PT_MAX, 1'b0);
        send_point(PT_MAX, 0, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(1, PT_MAX, 1'b1);
        // Steep lines far from the origin drive the intercept past both limits.
        send_point(1000, 0, 1'b0);
        send_point(1001, PT_MAX, 1'b1);
        send_point(1000, PT_MAX, 1'b0);
        send_point(1001, 0, 1'b1);
        send_point(5, 10, 1'b0);
        send_point(6, 3, 1'b0);
        send_point(700, 512, 1'b1);

        // 256 points at x = 0 with an odd y sum and one at x = 512 give a slope that is
        // an odd multiple of 2^-17, an exact half in Q16.16, once positive and once negative.
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 256; j++) send_point(0, PT_W'(j == 0), 1'b0);
            send_point(512, PT_W'(i == 0), 1'b1);
        end

        // A set that overruns capacity, with the last point itself dropped. Neither side
        // idles during this long stretch.
        no_idle = 1'b1;
        for (int i = 0; i <= MAX_POINTS + 1; i++) begin
            send_point(PT_W'($urandom_range(PT_MAX)), PT_W'($urandom_range(PT_MAX)),
                       i == MAX_POINTS + 1);
        end
        no_idle = 1'b0;

        sent = 0;
        while (sent < RANDOM_POINTS) begin
            shape    = $urandom_range(99);
            base_x   = $urandom_range(PT_MAX - 1);
            if (shape < 10) set_size = $urandom_range(6, 1);
            else if (shape < 20) set_size = $urandom_range(5, 2);
            else if (shape < 30) set_size = $urandom_range(4, 2);
            else if (shape < 35) set_size = $urandom_range(120, 20);
            else set_size = $urandom_range(10, 1);
            for (int unsigned i = 0; i < set_size; i++) begin
                x = PT_W'($urandom_range(PT_MAX));
                y = PT_W'($urandom_range(PT_MAX));
                if (shape < 10) begin
                    x = PT_W'(base_x);
                end else if (shape < 20) begin
                    if ($urandom_range(1)) x = $urandom_range(1) ? PT_W'(PT_MAX) : '0;
                    if ($urandom_range(1)) y = $urandom_range(1) ? PT_W'(PT_MAX) : '0;
                end else if (shape < 30) begin
                    x = PT_W'(base_x + $urandom_range(1));
                end
                send_point(x, y, i == set_size - 1);
                sent++;
            end
        end
        no_idle = 1'b0;
        pt.valid <= 1'b0;

        while (fits.pending_fits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fits.mismatches == 0 && fits.pending_fits.size() == 0) begin
            $display("least_squares_line_fit_top test passed");
        end else begin
            $display("least_squares_line_fit_top test failed");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/core/lslf_pkg.sv
rtl/core/lslf_if.sv
rtl/core/lslf_accum.sv
rtl/core/lslf_smul.sv
rtl/core/lslf_sdiv.sv
rtl/core/least_squares_line_fit_top.sv
rtl/core/lslf_chk.sv
sim/tb.sv
